>>> rtl/core/sstc_pkg.sv
// Package for the 3x3 smoothing stencil with threshold count.
// Holds widths, register indexes, reset values and the pipeline tag types.
// No dependencies.
package sstc_pkg;

    localparam int MAX_GRID   = 16384;
    localparam int SAMPLE_W   = 16;
    localparam int FRAC_W     = 16;
    localparam int ADDR_W     = $clog2(MAX_GRID);
    localparam int POS_W      = 14;
    localparam int GRID_W     = 15;
    localparam int SUM_W      = SAMPLE_W + 2;
    localparam int PROD_W     = 16 + SUM_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int COUNT_W    = 28;
    localparam int TALLY_W    = 29;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;
    localparam int STAGES     = 5;
    localparam int FILL_W     = FIFO_CNT_W + 1;

    localparam logic [GRID_W-1:0] GRID_MIN = GRID_W'(3);
    localparam logic [GRID_W-1:0] GRID_MAX = GRID_W'(MAX_GRID);

    localparam logic [GRID_W-1:0]   RST_GRID_SIZE = GRID_W'(16384);
    localparam logic [15:0]         RST_CORNER_W  = 16'd3277;
    localparam logic [15:0]         RST_EDGE_W    = 16'd6554;
    localparam logic [15:0]         RST_CENTER_W  = 16'd26214;
    localparam logic [SAMPLE_W-1:0] RST_THRESHOLD = SAMPLE_W'(6554);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_SIZE     = 3'd0,
        REG_CORNER_WEIGHT = 3'd1,
        REG_EDGE_WEIGHT   = 3'd2,
        REG_CENTER_WEIGHT = 3'd3,
        REG_THRESHOLD     = 3'd4
    } t_cfg_idx;

    // Per-item control that travels alongside the data path
    typedef struct packed {
        logic             produce;
        logic             clr;
        logic             last;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } t_tag;

    typedef struct packed {
        logic [SAMPLE_W-1:0] smoothed;
        logic [POS_W-1:0]    row;
        logic [POS_W-1:0]    col;
        logic [COUNT_W-1:0]  count;
        logic                last;
    } t_result;

endpackage

>>> rtl/core/stencil_smooth_threshold_count.sv
// Top level of the 3x3 smoothing stencil with threshold count.
// Uses sstc_pkg for widths, register indexes and tag types.
//
// Samples of a square grid enter on i_valid/o_stall in raster order, one word
// per clock at full rate while o_stall is low. Two line memories hold the two
// previous rows and a 3x3 window slides along the current row. Each interior
// cell yields one result word on o_valid/i_stall: the saturated weighted sum,
// its row and column, the running count of this frame's results below
// threshold, and a flag on the frame's last result. Border cells yield nothing.
// Pipeline: the word that completes a window goes through line memory read,
// window shift, neighbor sums, weight multiply, and add and saturate; the
// result then waits in an 8-word output FIFO.
// Throughput: one sample per cycle while o_stall is low; the rate is set by the
// single read-modify-write of each line memory per sample.
// o_stall rises when the words in flight plus the FIFO fill reach 8, so a
// stalled receiver only backs up the input, never drops a result.
// Reset restores the register defaults, returns to row 0, column 0 and
// clears the tally and the FIFO; line memory contents are not cleared.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data; the user keeps it to idle, unenforced.
module stencil_smooth_threshold_count (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [sstc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [sstc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [sstc_pkg::SAMPLE_W-1:0]        i_sample,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [sstc_pkg::SAMPLE_W-1:0]        o_smoothed,
    output logic [sstc_pkg::POS_W-1:0]           o_out_row,
    output logic [sstc_pkg::POS_W-1:0]           o_out_col,
    output logic [sstc_pkg::COUNT_W-1:0]         o_below_count,
    output logic                                 o_frame_last
);

    // configuration registers
    logic [sstc_pkg::GRID_W-1:0]   r_grid_size;
    logic [15:0]                   r_corner_w;
    logic [15:0]                   r_edge_w;
    logic [15:0]                   r_center_w;
    logic [sstc_pkg::SAMPLE_W-1:0] r_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= sstc_pkg::RST_GRID_SIZE;
            r_corner_w  <= sstc_pkg::RST_CORNER_W;
            r_edge_w    <= sstc_pkg::RST_EDGE_W;
            r_center_w  <= sstc_pkg::RST_CENTER_W;
            r_threshold <= sstc_pkg::RST_THRESHOLD;
        end else if (i_cfg_we) begin
            case (sstc_pkg::t_cfg_idx'(i_cfg_idx))
                sstc_pkg::REG_GRID_SIZE:     r_grid_size <= i_cfg_data[sstc_pkg::GRID_W-1:0];
                sstc_pkg::REG_CORNER_WEIGHT: r_corner_w  <= i_cfg_data;
                sstc_pkg::REG_EDGE_WEIGHT:   r_edge_w    <= i_cfg_data;
                sstc_pkg::REG_CENTER_WEIGHT: r_center_w  <= i_cfg_data;
                sstc_pkg::REG_THRESHOLD:     r_threshold <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage 0: position tracking and line memory read
    logic [sstc_pkg::GRID_W-1:0] grid_n;
    logic [sstc_pkg::POS_W-1:0]  r_col, r_row;
    logic [sstc_pkg::POS_W-1:0]  n_col, n_row;
    logic [sstc_pkg::POS_W-1:0]  cur_col, cur_row;
    logic [sstc_pkg::GRID_W-1:0] col_p1, row_p1;
    logic                        restart;
    logic                        in_acc;
    sstc_pkg::t_tag              tag0;

    always_comb begin
        if (r_grid_size < sstc_pkg::GRID_MIN) begin
            grid_n = sstc_pkg::GRID_MIN;
        end else if (r_grid_size > sstc_pkg::GRID_MAX) begin
            grid_n = sstc_pkg::GRID_MAX;
        end else begin
            grid_n = r_grid_size;
        end
    end

    always_comb begin
        // restart the frame if the grid shrank under the current position
        restart = ({1'b0, r_row} >= grid_n) || ({1'b0, r_col} >= grid_n);
        cur_col = restart ? '0 : r_col;
        cur_row = restart ? '0 : r_row;
        col_p1  = {1'b0, cur_col} + sstc_pkg::GRID_W'(1);
        row_p1  = {1'b0, cur_row} + sstc_pkg::GRID_W'(1);
        if (col_p1 >= grid_n) begin
            n_col = '0;
            n_row = (row_p1 >= grid_n) ? '0 : row_p1[sstc_pkg::POS_W-1:0];
        end else begin
            n_col = col_p1[sstc_pkg::POS_W-1:0];
            n_row = cur_row;
        end
        tag0.produce = (cur_row >= sstc_pkg::POS_W'(2)) && (cur_col >= sstc_pkg::POS_W'(2));
        tag0.clr     = (cur_row == '0) && (cur_col == '0);
        tag0.last    = (row_p1 == grid_n) && (col_p1 == grid_n);
        tag0.row     = cur_row - sstc_pkg::POS_W'(1);
        tag0.col     = cur_col - sstc_pkg::POS_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // line memories: read at accept, written back in the following cycle
    logic [sstc_pkg::SAMPLE_W-1:0] mem_upper  [sstc_pkg::MAX_GRID];
    logic [sstc_pkg::SAMPLE_W-1:0] mem_middle [sstc_pkg::MAX_GRID];
    logic [sstc_pkg::SAMPLE_W-1:0] r_rd_upper, r_rd_middle;
    logic [sstc_pkg::ADDR_W-1:0]   r_s1_addr;
    logic [sstc_pkg::SAMPLE_W-1:0] r_s1_sample;
    logic [sstc_pkg::STAGES-1:0]   r_v;
    sstc_pkg::t_tag                r_t1, r_t2, r_t3, r_t4, r_t5;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd_upper  <= mem_upper[cur_col[sstc_pkg::ADDR_W-1:0]];
            r_rd_middle <= mem_middle[cur_col[sstc_pkg::ADDR_W-1:0]];
        end
        if (r_v[0]) begin
            mem_upper[r_s1_addr]  <= r_rd_middle;
            mem_middle[r_s1_addr] <= r_s1_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_addr   <= cur_col[sstc_pkg::ADDR_W-1:0];
            r_s1_sample <= i_sample;
            r_t1        <= tag0;
        end
    end

    // stage 1: shift the window
    logic [sstc_pkg::SAMPLE_W-1:0] r_win [3][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[k][j] <= '0;
                end
            end
        end else if (r_v[0]) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k][0] <= r_win[k][1];
                r_win[k][1] <= r_win[k][2];
            end
            r_win[0][2] <= r_rd_upper;
            r_win[1][2] <= r_rd_middle;
            r_win[2][2] <= r_s1_sample;
        end
    end

    // stage 2: neighbor sums
    logic [sstc_pkg::SUM_W-1:0]    r_diag, r_side;
    logic [sstc_pkg::SAMPLE_W-1:0] r_center;

    always_ff @(posedge i_clk) begin
        if (r_v[1]) begin
            r_diag <= sstc_pkg::SUM_W'(r_win[0][0]) + sstc_pkg::SUM_W'(r_win[0][2])
                    + sstc_pkg::SUM_W'(r_win[2][0]) + sstc_pkg::SUM_W'(r_win[2][2]);
            r_side <= sstc_pkg::SUM_W'(r_win[0][1]) + sstc_pkg::SUM_W'(r_win[2][1])
                    + sstc_pkg::SUM_W'(r_win[1][0]) + sstc_pkg::SUM_W'(r_win[1][2]);
            r_center <= r_win[1][1];
        end
    end

    // stage 3: weight products
    logic [sstc_pkg::PROD_W-1:0] r_p_diag, r_p_side, r_p_center;

    always_ff @(posedge i_clk) begin
        if (r_v[2]) begin
            r_p_diag   <= sstc_pkg::PROD_W'(r_corner_w) * sstc_pkg::PROD_W'(r_diag);
            r_p_side   <= sstc_pkg::PROD_W'(r_edge_w) * sstc_pkg::PROD_W'(r_side);
            r_p_center <= sstc_pkg::PROD_W'(r_center_w) * sstc_pkg::PROD_W'(r_center);
        end
    end

    // stage 4: add, truncate, saturate, compare
    logic [sstc_pkg::ACC_W-1:0]                  acc;
    logic [sstc_pkg::ACC_W-sstc_pkg::FRAC_W-1:0] y_full;
    logic [sstc_pkg::SAMPLE_W-1:0]               y_sat;
    logic [sstc_pkg::SAMPLE_W-1:0]               r_y;
    logic                                        r_below;

    always_comb begin
        acc    = sstc_pkg::ACC_W'(r_p_diag) + sstc_pkg::ACC_W'(r_p_side)
               + sstc_pkg::ACC_W'(r_p_center);
        y_full = acc[sstc_pkg::ACC_W-1:sstc_pkg::FRAC_W];
        if (|y_full[sstc_pkg::ACC_W-sstc_pkg::FRAC_W-1:sstc_pkg::SAMPLE_W]) begin
            y_sat = '1;
        end else begin
            y_sat = y_full[sstc_pkg::SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v[3]) begin
            r_y     <= y_sat;
            r_below <= y_sat < r_threshold;
        end
    end

    // tag and valid pipeline; no internal stall, the FIFO absorbs backpressure
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[sstc_pkg::STAGES-2:0], in_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        r_t2 <= r_t1;
        r_t3 <= r_t2;
        r_t4 <= r_t3;
        r_t5 <= r_t4;
    end

    // stage 5: tally and push into the output FIFO
    logic [sstc_pkg::TALLY_W-1:0] r_tally, n_tally;
    logic                         push, pop;
    sstc_pkg::t_result            push_word;

    always_comb begin
        n_tally = r_t5.clr ? '0 : r_tally;
        if (r_t5.produce && r_below) begin
            n_tally = n_tally + sstc_pkg::TALLY_W'(1);
        end
        push               = r_v[4] && r_t5.produce;
        push_word.smoothed = r_y;
        push_word.row      = r_t5.row;
        push_word.col      = r_t5.col;
        push_word.count    = n_tally[sstc_pkg::COUNT_W-1:0];
        push_word.last     = r_t5.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tally <= '0;
        end else if (r_v[4]) begin
            r_tally <= n_tally;
        end
    end

    sstc_pkg::t_result                 r_fifo [sstc_pkg::FIFO_DEPTH];
    logic [sstc_pkg::FIFO_PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [sstc_pkg::FIFO_CNT_W-1:0]   r_fifo_cnt;
    logic [sstc_pkg::FILL_W-1:0]       fill;
    sstc_pkg::t_result                 head;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= push_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fifo_cnt <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + sstc_pkg::FIFO_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + sstc_pkg::FIFO_PTR_W'(1);
            end
            case ({push, pop})
                2'b10:   r_fifo_cnt <= r_fifo_cnt + sstc_pkg::FIFO_CNT_W'(1);
                2'b01:   r_fifo_cnt <= r_fifo_cnt - sstc_pkg::FIFO_CNT_W'(1);
                default: r_fifo_cnt <= r_fifo_cnt;
            endcase
        end
    end

    always_comb begin
        // reserve a FIFO slot for every word still in the pipeline
        fill    = sstc_pkg::FILL_W'($countones(r_v)) + sstc_pkg::FILL_W'(r_fifo_cnt);
        o_stall = fill >= sstc_pkg::FILL_W'(sstc_pkg::FIFO_DEPTH);
        in_acc  = i_valid && !o_stall;
        o_valid = r_fifo_cnt != '0;
        pop     = o_valid && !i_stall;
        head    = r_fifo[r_rd_ptr];
    end

    assign o_smoothed    = head.smoothed;
    assign o_out_row     = head.row;
    assign o_out_col     = head.col;
    assign o_below_count = head.count;
    assign o_frame_last  = head.last;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_fifo_cnt < sstc_pkg::FIFO_CNT_W'(sstc_pkg::FIFO_DEPTH)) || pop)
        else $error("output FIFO overflow");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fifo_cnt <= sstc_pkg::FIFO_CNT_W'(sstc_pkg::FIFO_DEPTH))
        else $error("FIFO count out of range");

    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out_row != '0) && (o_out_col != '0))
        else $error("result for a border cell");

    a_last_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_last |-> o_out_row == o_out_col)
        else $error("frame end off the corner");

    a_tally_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[4] && r_t5.clr |=> r_tally == '0)
        else $error("tally not cleared at frame start");
`endif

endmodule

>>> tb/smooth_stencil_checker.sv
// Checker for the 3x3 smoothing stencil: snoops config writes, predicts one
// result word per interior cell and compares accepted output words in order.
// Depends on sstc_pkg for widths, register indexes and the result struct.
module smooth_stencil_checker
    import sstc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [SAMPLE_W-1:0]   i_sample,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [SAMPLE_W-1:0]   i_smoothed,
    input  logic [POS_W-1:0]      i_out_row,
    input  logic [POS_W-1:0]      i_out_col,
    input  logic [COUNT_W-1:0]    i_below_count,
    input  logic                  i_frame_last,
    output int                    o_fail_cnt,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [GRID_W-1:0]   grid_reg;
    logic [15:0]         corner_w;
    logic [15:0]         edge_w;
    logic [15:0]         center_w;
    logic [SAMPLE_W-1:0] thr_level;

    logic [SAMPLE_W-1:0] upper_line [MAX_GRID];
    logic [SAMPLE_W-1:0] middle_line [MAX_GRID];
    logic [SAMPLE_W-1:0] win [3][3];   // [top..bottom][left..right]
    int unsigned         row_pos;
    int unsigned         col_pos;
    logic [TALLY_W-1:0]  tally;
    t_result             expected_cells [$];
    int                  errs;

    function automatic int unsigned grid_eff(input logic [GRID_W-1:0] g);
        if (g < GRID_MIN) return 3;
        if (g > GRID_MAX) return MAX_GRID;
        return g;
    endfunction

    // Shift one sample into the window and queue the cell it completes
    function automatic void predict_cell(input logic [SAMPLE_W-1:0] s);
        int unsigned     n;
        int unsigned     c;
        int unsigned     r;
        int              k;
        longint unsigned diag;
        longint unsigned side;
        longint unsigned acc;
        longint unsigned y;
        t_result         res_word;
        n = grid_eff(grid_reg);
        if (row_pos >= n || col_pos >= n) begin
            row_pos = 0;
            col_pos = 0;
        end
        c = col_pos;
        r = row_pos;
        if (r == 0 && c == 0) tally = '0;
        for (k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = upper_line[c];
        win[1][2] = middle_line[c];
        win[2][2] = s;
        upper_line[c]  = middle_line[c];
        middle_line[c] = s;
        if (r >= 2 && c >= 2) begin
            diag = win[0][0] + win[0][2] + win[2][0] + win[2][2];
            side = win[0][1] + win[2][1] + win[1][0] + win[1][2];
            acc  = corner_w * diag + edge_w * side + center_w * win[1][1];
            y    = acc >> FRAC_W;
            if (y > 64'hFFFF) y = 64'hFFFF;
            if (y < thr_level) tally = tally + 1'b1;
            res_word.smoothed = y[SAMPLE_W-1:0];
            res_word.row      = POS_W'(r - 1);
            res_word.col      = POS_W'(c - 1);
            res_word.count    = tally[COUNT_W-1:0];
            res_word.last     = (r == n - 1) && (c == n - 1);
            expected_cells.push_back(res_word);
        end
        if (c + 1 >= n) begin
            col_pos = 0;
            row_pos = (r + 1 >= n) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            errs++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            grid_reg  = RST_GRID_SIZE;
            corner_w  = RST_CORNER_W;
            edge_w    = RST_EDGE_W;
            center_w  = RST_CENTER_W;
            thr_level = RST_THRESHOLD;
            win       = '{default: '0};
            row_pos   = 0;
            col_pos   = 0;
            tally     = '0;
            errs      = 0;
            expected_cells.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_GRID_SIZE:     grid_reg  = i_cfg_data[GRID_W-1:0];
                    REG_CORNER_WEIGHT: corner_w  = i_cfg_data;
                    REG_EDGE_WEIGHT:   edge_w    = i_cfg_data;
                    REG_CENTER_WEIGHT: center_w  = i_cfg_data;
                    REG_THRESHOLD:     thr_level = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_cells.size() == 0) begin
                    $display("%0t: unexpected word smoothed %0d row %0d col %0d", $time,
                             i_smoothed, i_out_row, i_out_col);
                    errs++;
                end else begin
                    want = expected_cells.pop_front();
                    check_field("smoothed", want.smoothed, i_smoothed);
                    check_field("out_row", want.row, i_out_row);
                    check_field("out_col", want.col, i_out_col);
                    check_field("below_count", want.count, i_below_count);
                    check_field("frame_last", want.last, i_frame_last);
                end
            end
            if (i_in_valid && !i_in_stall) predict_cell(i_sample);
        end
        o_fail_cnt <= errs;
        o_pending  <= expected_cells.size();
    end

endmodule

>>> tb/stencil_smooth_threshold_count_tb.sv
// Testbench top for stencil_smooth_threshold_count: drives samples, config
// writes and output stalls, and gives the verdict from smooth_stencil_checker.
// Depends on sstc_pkg, the block and tb/smooth_stencil_checker.sv.
module stencil_smooth_threshold_count_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sstc_pkg::*;

    localparam int LAT_PAD      = 12;
    localparam int HOLD_LEN     = 120;
    localparam int QUIET_LIMIT  = 3000;
    localparam int RANDOM_ITEMS = 1200;
    localparam logic [CFG_IDX_W-1:0] UNMAPPED_REG = 3'd7;

    logic                  i_clk;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid    = 1'b0;
    logic [SAMPLE_W-1:0]   i_sample   = '0;
    logic                  i_stall    = 1'b0;
    logic                  o_stall;
    logic                  o_valid;
    logic [SAMPLE_W-1:0]   o_smoothed;
    logic [POS_W-1:0]      o_out_row;
    logic [POS_W-1:0]      o_out_col;
    logic [COUNT_W-1:0]    o_below_count;
    logic                  o_frame_last;

    int          fail_cnt;
    int          pend;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    logic        hold_go       = 1'b0;
    int          hold_left;
    int          quiet;
    // where the next sample lands, as far as stimulus needs to know
    int unsigned trk_row = 0;
    int unsigned trk_col = 0;
    int unsigned trk_n   = MAX_GRID;

    stencil_smooth_threshold_count dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_sample      (i_sample),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_smoothed    (o_smoothed),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_below_count (o_below_count),
        .o_frame_last  (o_frame_last)
    );

    smooth_stencil_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_sample      (i_sample),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_smoothed    (o_smoothed),
        .i_out_row     (o_out_row),
        .i_out_col     (o_out_col),
        .i_below_count (o_below_count),
        .i_frame_last  (o_frame_last),
        .o_fail_cnt    (fail_cnt),
        .o_pending     (pend)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Receiver: random stalls, or a long hold once requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            hold_left <= 0;
        end else if (hold_go) begin
            i_stall   <= 1'b1;
            hold_left <= HOLD_LEN;
        end else if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet == QUIET_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    function automatic int unsigned eff_grid(input logic [GRID_W-1:0] g);
        if (g < GRID_MIN) return 3;
        if (g > GRID_MAX) return MAX_GRID;
        return g;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int unsigned r;
        r = $urandom_range(19);
        if (r < 3) return $urandom_range(1) ? 16'hFFFF : 16'h0000;
        if (r < 6) return SAMPLE_W'($urandom_range(0, 4095));
        return SAMPLE_W'($urandom_range(0, 65535));
    endfunction

    task automatic send_word(input logic [SAMPLE_W-1:0] s);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= s;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (trk_row >= trk_n || trk_col >= trk_n) begin
            trk_row = 0;
            trk_col = 0;
        end
        if (trk_col + 1 >= trk_n) begin
            trk_col = 0;
            trk_row = (trk_row + 1 >= trk_n) ? 0 : trk_row + 1;
        end else begin
            trk_col = trk_col + 1;
        end
    endtask

    // Drop valid and hold until every predicted word has come out
    task automatic wait_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pend != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
    endtask

    task automatic apply_config(input logic [15:0] grid_word, input logic [15:0] cw,
                                input logic [15:0] ew, input logic [15:0] mw,
                                input logic [15:0] th);
        int unsigned n_next;
        n_next = eff_grid(grid_word[GRID_W-1:0]);
        wait_results();
        // a grid that grows mid-frame would read line entries never written
        if (n_next > trk_n && (trk_row != 0 || trk_col != 0)) begin
            while (trk_row != 0 || trk_col != 0) send_word(pick_sample());
            wait_results();
        end
        repeat (LAT_PAD) @(posedge i_clk);
        write_reg(REG_GRID_SIZE, grid_word);
        write_reg(REG_CORNER_WEIGHT, cw);
        write_reg(REG_EDGE_WEIGHT, ew);
        write_reg(REG_CENTER_WEIGHT, mw);
        write_reg(REG_THRESHOLD, th);
        write_reg(UNMAPPED_REG, CFG_DATA_W'($urandom_range(0, 65535)));
        i_cfg_we <= 1'b0;
        trk_n = n_next;
    endtask

    initial begin
        int unsigned p;
        int unsigned k;
        int unsigned g;
        int unsigned n_items;
        int          sent;
        logic [15:0] gw;
        logic [15:0] cw;
        logic [15:0] ew;
        logic [15:0] mw;
        logic [15:0] th;
        sent = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // grid above the maximum: a few border samples, no words out
        apply_config(16'hFFFF, RST_CORNER_W, RST_EDGE_W, RST_CENTER_W, RST_THRESHOLD);
        send_word(16'h0000);
        send_word(16'hFFFF);
        send_word(16'h5A5A);
        // shrink below the minimum mid-frame: restart, full-scale saturates
        apply_config(16'h0001, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        repeat (9) send_word(16'hFFFF);
        // zero weights, next frame clears the tally
        apply_config(16'h8002, 16'h0000, 16'h0000, 16'h0000, 16'h0001);
        for (k = 0; k < 9; k++) send_word(k[0] ? 16'hFFFF : 16'h0000);

        for (p = 0; sent < RANDOM_ITEMS; p++) begin
            case ($urandom_range(9))
                0:       g = $urandom_range(0, 2);
                1:       g = $urandom_range(16384, 32767);
                2:       g = $urandom_range(16, 24);
                default: g = $urandom_range(3, 10);
            endcase
            if (p == 0) g = 5;
            if (g > MAX_GRID) n_items = 40;
            else if (g >= 16) n_items = g * g + $urandom_range(0, 2 * g);
            else n_items = $urandom_range(60, 140);
            if (p == 0) n_items = 200;
            gw = {1'($urandom_range(1)), 15'(g)};
            case ($urandom_range(3))
                0: begin
                    cw = RST_CORNER_W;
                    ew = RST_EDGE_W;
                    mw = RST_CENTER_W;
                end
                1: begin
                    cw = 16'($urandom_range(0, 65535));
                    ew = 16'($urandom_range(0, 65535));
                    mw = 16'($urandom_range(0, 65535));
                end
                2: begin
                    cw = 16'($urandom_range(0, 9000));
                    ew = 16'($urandom_range(0, 9000));
                    mw = 16'($urandom_range(0, 9000));
                end
                default: begin
                    cw = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                    ew = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                    mw = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                end
            endcase
            case ($urandom_range(4))
                0:       th = 16'h0000;
                1:       th = 16'hFFFF;
                default: th = 16'($urandom_range(0, 65535));
            endcase
            apply_config(gw, cw, ew, mw, th);

            case (p % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct    <= 0;
                end
                1: begin
                    send_idle_pct = 59;
                    stall_pct    <= 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct    <= 59;
                end
                default: begin
                    send_idle_pct = 21;
                    stall_pct    <= 21;
                end
            endcase

            for (k = 0; k < n_items; k++) begin
                // long receiver hold while samples keep coming: fill and back up
                if (p == 0 && k == 20) hold_go <= 1'b1;
                if (p == 0 && k == 21) hold_go <= 1'b0;
                if (p == 2 && k == n_items / 2) wait_results();
                send_word(pick_sample());
                sent++;
            end
        end

        wait_results();
        repeat (LAT_PAD) @(posedge i_clk);
        if (fail_cnt == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> files.f
rtl/core/sstc_pkg.sv
rtl/core/stencil_smooth_threshold_count.sv
tb/smooth_stencil_checker.sv
tb/stencil_smooth_threshold_count_tb.sv
